### design/mssm_pkg.sv
// Types and constants shared by the mouse sensor serial master.
// No dependencies.
package mssm_pkg;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_HALF_BIT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_WAIT     = 2'd1;

	localparam logic [7:0]  HALF_BIT_RESET = 8'd4;
	localparam logic [15:0] WAIT_RESET     = 16'd1600;

	typedef enum logic [2:0] {
		PH_IDLE = 3'd0,
		PH_ADDR = 3'd1,
		PH_DATA = 3'd2,
		PH_WAIT = 3'd3,
		PH_RECV = 3'd4
	} phase_t;

	typedef struct packed {
		logic                  we;
		logic [CFG_IDX_W-1:0]  index;
		logic [CFG_DATA_W-1:0] wdata;
	} cfg_wr_t;

	typedef struct packed {
		logic       start_req;
		logic       opcode;
		logic [6:0] address;
		logic [7:0] write_data;
		logic       sda_in;
	} in_item_t;

	typedef struct packed {
		logic       sck;
		logic       sda_out;
		logic       sda_drive;
		logic       busy_res;
		logic       done_res;
		logic [7:0] read_data;
	} res_item_t;

endpackage

### design/mssm_queue.sv
// Small register queue with full/empty flags; transfer on push & !full, pop & !empty.
// Depends on nothing.
module mssm_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] din,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] dout,
	output logic             empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push, do_pop;

	assign full    = (count_q == FULL_CNT);
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_CNT) else $error("queue count beyond depth");
	a_full_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(full && !pop) |=> full) else $error("full queue lost an entry");
	a_empty_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(empty && !push) |=> empty) else $error("empty queue gained an entry");

endmodule

### design/mssm_engine.sv
// Serial bit engine: one tick per queued item, one result per tick.
// Depends on mssm_pkg.
module mssm_engine
	import mssm_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  cfg_wr_t   cfg,
	input  in_item_t  item,
	input  logic      item_valid,
	output logic      item_pop,
	output res_item_t res,
	output logic      res_push,
	input  logic      res_full
);

	logic [7:0]  half_q;
	logic [15:0] wait_q;

	phase_t      phase_q, phase_d;
	logic [7:0]  shift_q, shift_d;
	logic [7:0]  second_q, second_d;
	logic [3:0]  bit_q, bit_d;
	logic [15:0] tick_q, tick_d;
	logic        write_q, write_d;
	logic        clock_q, clock_d;
	logic        drive_q, drive_d;
	logic [7:0]  recv_q, recv_d;

	logic        step, done, leave;
	logic [7:0]  half_eff;
	logic [3:0]  bit_inc;

	assign step     = item_valid && !res_full;
	assign item_pop = step;
	assign res_push = step;
	assign half_eff = (half_q == '0) ? 8'd1 : half_q;
	assign bit_inc  = bit_q + 4'd1;

	always_comb begin
		phase_d  = phase_q;
		shift_d  = shift_q;
		second_d = second_q;
		bit_d    = bit_q;
		tick_d   = tick_q;
		write_d  = write_q;
		clock_d  = clock_q;
		drive_d  = drive_q;
		recv_d   = recv_q;
		done     = 1'b0;
		leave    = 1'b0;
		unique case (phase_q)
			PH_IDLE: begin
				if (item.start_req) begin
					write_d  = item.opcode;
					second_d = item.write_data;
					drive_d  = 1'b1;
					phase_d  = PH_ADDR;
					shift_d  = {item.opcode, item.address};
					bit_d    = '0;
					clock_d  = 1'b0;
					tick_d   = 16'd1;
				end
			end
			PH_WAIT: begin
				if (tick_q < wait_q) begin
					tick_d = tick_q + 16'd1;
				end else begin
					leave = 1'b1;
				end
			end
			PH_ADDR, PH_DATA, PH_RECV: begin
				if (tick_q < {8'd0, half_eff}) begin
					tick_d = tick_q + 16'd1;
				end else if (!clock_q) begin
					clock_d = 1'b1;
					tick_d  = 16'd1;
					if (phase_q == PH_RECV) begin
						shift_d = {shift_q[6:0], item.sda_in};
					end
				end else begin
					bit_d = bit_inc;
					if (bit_inc < 4'd8) begin
						if (phase_q != PH_RECV) begin
							shift_d = {shift_q[6:0], 1'b0};
						end
						clock_d = 1'b0;
						tick_d  = 16'd1;
					end else if (phase_q == PH_ADDR && write_q) begin
						phase_d = PH_DATA;
						shift_d = second_q;
						bit_d   = '0;
						clock_d = 1'b0;
						tick_d  = 16'd1;
					end else if (phase_q == PH_RECV) begin
						recv_d  = shift_q;
						phase_d = PH_IDLE;
						done    = 1'b1;
					end else begin
						phase_d = PH_WAIT;
						if (wait_q == '0) begin
							leave = 1'b1;
						end else begin
							tick_d = 16'd1;
						end
					end
				end
			end
			default: begin
				phase_d = PH_IDLE;
			end
		endcase
		if (leave) begin
			if (write_q) begin
				phase_d = PH_IDLE;
				done    = 1'b1;
			end else begin
				drive_d = 1'b0;
				phase_d = PH_RECV;
				shift_d = '0;
				bit_d   = '0;
				clock_d = 1'b0;
				tick_d  = 16'd1;
			end
		end
	end

	always_comb begin
		res.sck       = clock_d;
		res.sda_out   = drive_d & shift_d[7];
		res.sda_drive = drive_d;
		res.busy_res  = (phase_d != PH_IDLE);
		res.done_res  = done;
		res.read_data = recv_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_q   <= HALF_BIT_RESET;
			wait_q   <= WAIT_RESET;
			phase_q  <= PH_IDLE;
			shift_q  <= '0;
			second_q <= '0;
			bit_q    <= '0;
			tick_q   <= '0;
			write_q  <= 1'b0;
			clock_q  <= 1'b0;
			drive_q  <= 1'b0;
			recv_q   <= '0;
		end else begin
			if (cfg.we && cfg.index == CFG_HALF_BIT) begin
				half_q <= cfg.wdata[7:0];
			end
			if (cfg.we && cfg.index == CFG_WAIT) begin
				wait_q <= cfg.wdata;
			end
			if (step) begin
				phase_q  <= phase_d;
				shift_q  <= shift_d;
				second_q <= second_d;
				bit_q    <= bit_d;
				tick_q   <= tick_d;
				write_q  <= write_d;
				clock_q  <= clock_d;
				drive_q  <= drive_d;
				recv_q   <= recv_d;
			end
		end
	end

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(step && done) |-> (phase_q != PH_IDLE && phase_d == PH_IDLE))
		else $error("done outside a transaction end");
	a_wait_clock_high: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_WAIT) |-> clock_q) else $error("clock low in pause");
	a_recv_released: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_RECV) |-> !drive_q) else $error("line driven while receiving");
	a_bit_range: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q != PH_IDLE && phase_q != PH_WAIT) |-> (bit_q < 4'd8))
		else $error("bit count out of range");

endmodule

### design/mouse_sensor_serial_master_unit.sv
// Mouse sensor serial master: input queue, bit engine, result queue.
// Each tick item is registered in the input queue and its result in the
// result queue; engine moves one item per cycle unless that queue is full.
// Reset (arst_n low, asynchronous): queues empty, engine idle, clock and data
// released low, half_bit_ticks 4, wait_ticks 1600.
module mouse_sensor_serial_master_unit
	import mssm_pkg::*;
#(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  logic                  push,
	output logic                  full,
	input  logic                  start_req,
	input  logic                  opcode,
	input  logic [6:0]            address,
	input  logic [7:0]            write_data,
	input  logic                  sda_in,
	output logic                  empty,
	input  logic                  pop,
	output logic                  sck,
	output logic                  sda_out,
	output logic                  sda_drive,
	output logic                  busy_res,
	output logic                  done_res,
	output logic [7:0]            read_data
);

	localparam int IN_W  = $bits(in_item_t);
	localparam int RES_W = $bits(res_item_t);

	cfg_wr_t   cfg;
	in_item_t  in_item, eng_item;
	res_item_t eng_res, out_res;
	logic      eng_valid, eng_empty, eng_pop, res_push, res_full;

	assign cfg     = '{we: cfg_we, index: cfg_index, wdata: cfg_wdata};
	assign in_item = '{start_req: start_req, opcode: opcode, address: address,
		write_data: write_data, sda_in: sda_in};
	assign eng_valid = !eng_empty;

	mssm_queue #(.WIDTH(IN_W), .DEPTH(QUEUE_DEPTH)) u_in_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.din   (in_item),
		.full  (full),
		.pop   (eng_pop),
		.dout  (eng_item),
		.empty (eng_empty)
	);

	mssm_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.item      (eng_item),
		.item_valid(eng_valid),
		.item_pop  (eng_pop),
		.res       (eng_res),
		.res_push  (res_push),
		.res_full  (res_full)
	);

	mssm_queue #(.WIDTH(RES_W), .DEPTH(QUEUE_DEPTH)) u_res_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (res_push),
		.din   (eng_res),
		.full  (res_full),
		.pop   (pop),
		.dout  (out_res),
		.empty (empty)
	);

	assign sck       = out_res.sck;
	assign sda_out   = out_res.sda_out;
	assign sda_drive = out_res.sda_drive;
	assign busy_res  = out_res.busy_res;
	assign done_res  = out_res.done_res;
	assign read_data = out_res.read_data;

endmodule

### verif/testbench.sv
`timescale 1ns / 1ps
// Testbench for mouse_sensor_serial_master_unit: drives tick items into the input queue
// and checks every result against a cycle-level model of the serial engine.
// Depends on mssm_pkg and the unit itself.
module testbench;
	import mssm_pkg::*;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;
	logic                  push;
	logic                  full;
	logic                  start_req;
	logic                  opcode;
	logic [6:0]            address;
	logic [7:0]            write_data;
	logic                  sda_in;
	logic                  empty;
	logic                  pop;
	logic                  sck;
	logic                  sda_out;
	logic                  sda_drive;
	logic                  busy_res;
	logic                  done_res;
	logic [7:0]            read_data;

	mouse_sensor_serial_master_unit dut (.*);

	in_item_t  tick_q[$];
	res_item_t line_q[$];

	int  mismatches;
	int  results_seen;
	int  cur_half;
	int  cur_pause;
	int  send_gap;
	int  recv_gap;
	int  hold_left;
	bit  hold_used;
	bit  steady;
	bit  in_xfer;

	// engine model
	phase_t     m_phase;
	logic [7:0] m_shift;
	logic [7:0] m_second;
	logic [7:0] m_rx;
	logic [3:0] m_bits;
	logic [15:0] m_ticks;
	logic       m_wr;
	logic       m_clk;
	logic       m_drv;
	logic [7:0] m_half;
	logic [15:0] m_pause;

	function automatic void start_bit();
		m_clk = 1'b0;
		m_ticks = 16'd1;
	endfunction

	function automatic void load_byte(phase_t ph, logic [7:0] value);
		m_phase = ph;
		m_shift = value;
		m_bits = 4'd0;
		start_bit();
	endfunction

	function automatic logic leave_pause();
		if (m_wr) begin
			m_phase = PH_IDLE;
			return 1'b1;
		end
		m_drv = 1'b0;
		load_byte(PH_RECV, 8'h00);
		return 1'b0;
	endfunction

	function automatic logic enter_pause();
		m_phase = PH_WAIT;
		if (m_pause == 16'd0)
			return leave_pause();
		m_ticks = 16'd1;
		return 1'b0;
	endfunction

	function automatic logic bit_step(logic sda);
		logic [15:0] h;
		h = (m_half == 8'd0) ? 16'd1 : {8'h00, m_half};
		if (m_ticks < h) begin
			m_ticks = m_ticks + 16'd1;
			return 1'b0;
		end
		if (!m_clk) begin
			m_clk = 1'b1;
			m_ticks = 16'd1;
			if (m_phase == PH_RECV)
				m_shift = {m_shift[6:0], sda};
			return 1'b0;
		end
		m_bits = m_bits + 4'd1;
		if (m_bits < 4'd8) begin
			if (m_phase != PH_RECV)
				m_shift = {m_shift[6:0], 1'b0};
			start_bit();
			return 1'b0;
		end
		if (m_phase == PH_ADDR) begin
			if (m_wr) begin
				load_byte(PH_DATA, m_second);
				return 1'b0;
			end
			return enter_pause();
		end
		if (m_phase == PH_DATA)
			return enter_pause();
		m_rx = m_shift;
		m_phase = PH_IDLE;
		return 1'b1;
	endfunction

	function automatic res_item_t sdio_tick(in_item_t it);
		logic      fin;
		res_item_t r;
		fin = 1'b0;
		case (m_phase)
			PH_IDLE: begin
				if (it.start_req) begin
					m_wr = it.opcode;
					m_second = it.write_data;
					m_drv = 1'b1;
					load_byte(PH_ADDR, {it.opcode, it.address});
				end
			end
			PH_WAIT: begin
				if (m_ticks < m_pause)
					m_ticks = m_ticks + 16'd1;
				else
					fin = leave_pause();
			end
			PH_ADDR, PH_DATA, PH_RECV: begin
				fin = bit_step(it.sda_in);
			end
			default: begin
				m_phase = PH_IDLE;
			end
		endcase
		r.sck = m_clk;
		r.sda_out = m_drv ? m_shift[7] : 1'b0;
		r.sda_drive = m_drv;
		r.busy_res = (m_phase != PH_IDLE);
		r.done_res = fin;
		r.read_data = m_rx;
		return r;
	endfunction

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// model update, expectation store, result check
	always @(posedge clk) begin
		res_item_t got;
		res_item_t exp_r;
		if (!arst_n) begin
			m_phase = PH_IDLE;
			m_shift = '0;
			m_second = '0;
			m_rx = '0;
			m_bits = '0;
			m_ticks = '0;
			m_wr = 1'b0;
			m_clk = 1'b0;
			m_drv = 1'b0;
			m_half = HALF_BIT_RESET;
			m_pause = WAIT_RESET;
			in_xfer = 1'b0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == CFG_HALF_BIT)
					m_half = cfg_wdata[7:0];
				else if (cfg_index == CFG_WAIT)
					m_pause = cfg_wdata;
			end
			in_xfer = push && !full;
			if (in_xfer)
				line_q.push_back(sdio_tick('{start_req, opcode, address, write_data, sda_in}));
			if (pop && !empty) begin
				got = '{sck, sda_out, sda_drive, busy_res, done_res, read_data};
				results_seen++;
				if (line_q.size() == 0) begin
					if (mismatches < 10)
						$display("unexpected result transfer: %p", got);
					mismatches++;
				end else begin
					exp_r = line_q.pop_front();
					if (got.sck !== exp_r.sck || got.sda_out !== exp_r.sda_out ||
						got.sda_drive !== exp_r.sda_drive || got.busy_res !== exp_r.busy_res ||
						got.done_res !== exp_r.done_res || got.read_data !== exp_r.read_data) begin
						if (mismatches < 10)
							$display("result %0d: exp %p got %p", results_seen, exp_r, got);
						mismatches++;
					end
				end
			end
		end
	end

	// sender
	always @(negedge clk) begin
		logic nxt_push;
		if (arst_n) begin
			if (in_xfer)
				void'(tick_q.pop_front());
			nxt_push = push && !in_xfer;
			if (!nxt_push) begin
				if (send_gap > 0)
					send_gap--;
				else if (tick_q.size() > 0) begin
					if (!steady && $urandom_range(0, 7) == 0)
						send_gap = $urandom_range(0, 14);
					else
						nxt_push = 1'b1;
				end
			end
			if (nxt_push) begin
				start_req <= tick_q[0].start_req;
				opcode <= tick_q[0].opcode;
				address <= tick_q[0].address;
				write_data <= tick_q[0].write_data;
				sda_in <= tick_q[0].sda_in;
			end
			push <= nxt_push;
		end
	end

	// receiver; one long hold-off fills the unit and backs up the input
	always @(negedge clk) begin
		if (arst_n) begin
			if (!hold_used && results_seen >= 100) begin
				hold_used = 1'b1;
				hold_left = 300;
			end
			if (hold_left > 0) begin
				hold_left--;
				pop <= 1'b0;
			end else if (recv_gap > 0) begin
				recv_gap--;
				pop <= 1'b0;
			end else if (!steady && $urandom_range(0, 7) == 0) begin
				recv_gap = $urandom_range(0, 14);
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	task automatic set_timing(input logic [7:0] half, input logic [15:0] pause);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= CFG_HALF_BIT;
		cfg_wdata <= {8'h00, half};
		@(negedge clk);
		cfg_index <= CFG_WAIT;
		cfg_wdata <= pause;
		@(negedge clk);
		cfg_we <= 1'b0;
		cur_half = (half == 8'd0) ? 1 : int'(half);
		cur_pause = int'(pause);
	endtask

	// idle ticks long enough for any transaction under the current timing to finish
	task automatic queue_tail(input bit sda);
		in_item_t it;
		for (int i = 0; i < 32 * cur_half + cur_pause + 4; i++) begin
			it.start_req = 1'b0;
			it.opcode = 1'($urandom);
			it.address = 7'($urandom);
			it.write_data = 8'($urandom);
			it.sda_in = sda;
			tick_q.push_back(it);
		end
	endtask

	// one transaction; with spam set, the first half of its ticks repeat the start
	task automatic queue_txn(input bit op, input logic [6:0] addr, input logic [7:0] data,
		input bit sda, input bit spam);
		in_item_t it;
		int       n;
		n = 32 * cur_half + cur_pause + 4;
		it = '{1'b1, op, addr, data, sda};
		tick_q.push_back(it);
		for (int i = 0; i < n; i++) begin
			it.start_req = spam && (i < n / 2);
			it.opcode = 1'($urandom);
			it.address = 7'($urandom);
			it.write_data = 8'($urandom);
			it.sda_in = sda;
			tick_q.push_back(it);
		end
	endtask

	// a start followed by count ticks that repeat it; the transaction stays open
	task automatic queue_open(input bit op, input logic [6:0] addr, input logic [7:0] data,
		input bit sda, input int count);
		in_item_t it;
		it = '{1'b1, op, addr, data, sda};
		tick_q.push_back(it);
		for (int i = 0; i < count; i++) begin
			it.opcode = 1'($urandom);
			it.address = 7'($urandom);
			it.write_data = 8'($urandom);
			tick_q.push_back(it);
		end
	endtask

	task automatic random_ticks(input int count);
		in_item_t it;
		for (int i = 0; i < count; i++) begin
			it.start_req = ($urandom_range(0, 3) == 0);
			it.opcode = 1'($urandom);
			it.address = 7'($urandom);
			it.write_data = 8'($urandom);
			it.sda_in = 1'($urandom);
			tick_q.push_back(it);
		end
		queue_tail(1'($urandom));
	endtask

	task automatic drain();
		while (tick_q.size() != 0 || push || line_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_HALF_BIT;
		cfg_wdata = '0;
		push = 1'b0;
		pop = 1'b0;
		start_req = 1'b0;
		opcode = 1'b0;
		address = '0;
		write_data = '0;
		sda_in = 1'b0;
		mismatches = 0;
		results_seen = 0;
		send_gap = 0;
		recv_gap = 0;
		hold_left = 0;
		hold_used = 1'b0;
		steady = 1'b0;
		cur_half = int'(HALF_BIT_RESET);
		cur_pause = int'(WAIT_RESET);
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset timing: read of all ones, starts repeated while busy; the pause
		// is cut short by a timing write once it is under way
		queue_open(1'b0, 7'h00, 8'h00, 1'b1, 120);
		drain();
		set_timing(8'd4, 16'd8);
		queue_tail(1'b1);
		drain();

		// zero half period and zero pause
		set_timing(8'd0, 16'd0);
		queue_txn(1'b1, 7'h7f, 8'hff, 1'b0, 1'b1);
		queue_txn(1'b0, 7'h55, 8'h00, 1'b0, 1'b0);
		drain();

		set_timing(8'd1, 16'd1);
		queue_txn(1'b1, 7'h00, 8'h00, 1'b1, 1'b1);
		queue_txn(1'b0, 7'h2a, 8'hff, 1'b1, 1'b0);
		drain();

		// slowest timing, cut short while the first bit has the clock high
		set_timing(8'd255, 16'hffff);
		queue_open(1'b1, 7'h7f, 8'ha5, 1'b0, 260);
		drain();
		set_timing(8'd1, 16'd2);
		queue_tail(1'b0);
		drain();

		for (int k = 0; k < 5; k++) begin
			set_timing(8'($urandom_range(0, 3)),
				(k == 2) ? 16'd40 : 16'($urandom_range(0, 6)));
			if (k == 4)
				steady = 1'b1;
			random_ticks(25);
			drain();
		end

		repeat (10) @(posedge clk);
		if (mismatches == 0 && line_q.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	initial begin
		#40_000_000;
		$display("FAIL");
		$finish;
	end

endmodule

### mouse_sensor_serial_master_unit.f
design/mssm_pkg.sv
design/mssm_queue.sv
design/mssm_engine.sv
design/mouse_sensor_serial_master_unit.sv
verif/testbench.sv
